FILE: hdl/vomf_pkg.sv
// Shared types and constants for the voxel occupancy map filter.
// Used by vomf_accum and voxel_occupancy_map_filter; depends on nothing.
`default_nettype none
package vomf_pkg;

  localparam int GRID_DIM_BITS_DEF   = 5;
  localparam int NEIGHBOR_RADIUS_DEF = 1;

  localparam int COORD_W = 5;
  localparam int VAL_W   = 8;
  localparam int CNT_W   = 9;
  localparam int CMD_W   = 2;
  localparam int MASK_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 9;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

  localparam logic [MASK_W-1:0] CLS_UNOBSERVED = 3'b001;
  localparam logic [MASK_W-1:0] CLS_EMPTY      = 3'b010;
  localparam logic [MASK_W-1:0] CLS_OCCUPIED   = 3'b100;

  localparam logic [CFG_IDX_W-1:0] REG_OCC_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_UNOBS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_UNOBS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_EMPTY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EMPTY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OCC     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OCC     = 3'd7;

  localparam logic [6:0]       OCC_LIMIT_RST   = 7'd127;
  localparam logic [7:0]       EMPTY_LIMIT_RST = 8'd128;
  localparam logic [CNT_W-1:0] MIN_BOUND_RST   = 9'd0;
  localparam logic [CNT_W-1:0] MAX_BOUND_RST   = 9'd343;

  typedef struct packed {
    logic clr;
    logic vld;
    logic in_grid;
    logic finish;
  } acc_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] min_unobs;
    logic [CNT_W-1:0] max_unobs;
    logic [CNT_W-1:0] min_emp;
    logic [CNT_W-1:0] max_emp;
    logic [CNT_W-1:0] min_occ;
    logic [CNT_W-1:0] max_occ;
  } cnt_bounds_t;

  typedef struct packed {
    logic [CNT_W-1:0] unobs;
    logic [CNT_W-1:0] empty;
    logic [CNT_W-1:0] occ;
  } nbr_counts_t;

endpackage
`default_nettype wire

FILE: hdl/vomf_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module vomf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: hdl/vomf_accum.sv
// Neighbor class counter and count bound checker of the voxel filter.
// Depends on vomf_pkg.
`default_nettype none
module vomf_accum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vomf_pkg::acc_ctl_t          ctl,
  input  wire logic signed [vomf_pkg::VAL_W-1:0] rd_data,
  input  wire vomf_pkg::cnt_bounds_t       bounds,
  output vomf_pkg::nbr_counts_t            counts,
  output logic                             bounds_ok
);

  vomf_pkg::nbr_counts_t cnt_r;
  vomf_pkg::nbr_counts_t cnt_nxt;
  logic                  ok_r;
  logic                  ok_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    ok_nxt  = ok_r;
    if (ctl.clr) begin
      cnt_nxt = '0;
      ok_nxt  = 1'b0;
    end else if (ctl.vld) begin
      if (!ctl.in_grid || rd_data == '0) begin
        cnt_nxt.unobs = cnt_r.unobs + 1'b1;
      end else if (rd_data > 0) begin
        cnt_nxt.occ = cnt_r.occ + 1'b1;
      end else begin
        cnt_nxt.empty = cnt_r.empty + 1'b1;
      end
    end else if (ctl.finish) begin
      ok_nxt = (cnt_r.unobs >= bounds.min_unobs) && (cnt_r.unobs <= bounds.max_unobs) &&
               (cnt_r.empty >= bounds.min_emp) && (cnt_r.empty <= bounds.max_emp) &&
               (cnt_r.occ >= bounds.min_occ) && (cnt_r.occ <= bounds.max_occ);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ok_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ok_r  <= ok_nxt;
    end
  end

  assign counts    = cnt_r;
  assign bounds_ok = ok_r;

endmodule
`default_nettype wire

FILE: hdl/voxel_occupancy_map_filter.sv
// Top level of the voxel occupancy map filter: sequencer, clip unit and ports.
// Depends on vomf_pkg, vomf_ram and vomf_accum.
//
// After reset the block sweeps the voxel memory to zero, one cell per cycle;
// no beat is taken on the input meanwhile, while configuration writes are.
// All memory traffic goes through one single-port RAM, one access per cycle.
// An update or a query reads the center cell in S_CTR and S_CTR_DATA and
// loads its result in S_DONE; a test reads the center, then the neighbors
// one after another in S_WALK, then drains the count in S_DRAIN, compares
// the bounds in S_CMP and loads the output in S_DONE. The load waits in
// S_DONE while an earlier result is still unaccepted. The input is ready
// again in the cycle after the load, so a new beat is taken only once the
// previous one is finished. A finished result sits in an output register,
// so the next beat is taken while it waits.
`default_nettype none
module voxel_occupancy_map_filter #(
  parameter int GRID_DIM_BITS   = vomf_pkg::GRID_DIM_BITS_DEF,
  parameter int NEIGHBOR_RADIUS = vomf_pkg::NEIGHBOR_RADIUS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cell_x, cell_y, cell_z, delta, accept_types, zero fill
  input  wire logic [31:0] in_tdata,
  // cmd
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cell_value, type_accepted, passed, unobserved_count, empty_count,
  // occupied_count, zero fill
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [vomf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vomf_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int ADDR_W  = 3 * GRID_DIM_BITS;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int CRD_W   = ((GRID_DIM_BITS > vomf_pkg::COORD_W) ?
                            GRID_DIM_BITS : vomf_pkg::COORD_W) + 3;
  localparam int OFS_W   = $clog2(NEIGHBOR_RADIUS + 1) + 1;
  localparam int NBR_CNT = (2 * NEIGHBOR_RADIUS + 1) ** 3;
  localparam logic signed [CRD_W-1:0] DIM_S  = CRD_W'(1 << GRID_DIM_BITS);
  localparam logic signed [OFS_W-1:0] OFS_HI = OFS_W'(NEIGHBOR_RADIUS);
  localparam logic signed [OFS_W-1:0] OFS_LO = -OFS_HI;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CTR, S_CTR_DATA, S_WALK, S_DRAIN, S_CMP, S_DONE
  } state_t;

  state_t                              state_r, state_nxt;
  logic [ADDR_W-1:0]                   clr_cnt_r, clr_cnt_nxt;
  logic [vomf_pkg::CMD_W-1:0]          cmd_r, cmd_nxt;
  logic [vomf_pkg::COORD_W-1:0]        x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [vomf_pkg::VAL_W-1:0]   delta_r, delta_nxt;
  logic [vomf_pkg::MASK_W-1:0]         mask_r, mask_nxt;
  logic signed [OFS_W-1:0]             dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic                                pend_vld_r, pend_vld_nxt;
  logic                                pend_in_r, pend_in_nxt;
  logic signed [vomf_pkg::VAL_W-1:0]   value_r, value_nxt;
  logic                                acc_r, acc_nxt;
  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [39:0]                         out_tdata_r, out_tdata_nxt;

  logic [6:0]                          occ_limit_r;
  logic [7:0]                          empty_limit_r;
  vomf_pkg::cnt_bounds_t               bounds_r;

  logic signed [OFS_W-1:0]             ox, oy, oz;
  logic signed [CRD_W-1:0]             nx, ny, nz;
  logic                                coord_inside;
  logic [ADDR_W-1:0]                   nbr_addr;

  logic                                ram_we;
  logic [ADDR_W-1:0]                   ram_addr;
  logic [vomf_pkg::VAL_W-1:0]          ram_wdata;
  logic [vomf_pkg::VAL_W-1:0]          ram_rdata;

  logic signed [vomf_pkg::VAL_W-1:0]   ctr_val;
  logic [vomf_pkg::MASK_W-1:0]         ctr_cls;
  logic [7:0]                          lo_mag;
  logic signed [9:0]                   sum, lo, hi, clipped;
  logic                                walk_last;

  vomf_pkg::acc_ctl_t                  acc_ctl;
  vomf_pkg::nbr_counts_t               counts;
  logic                                bounds_ok;

  // Neighbor coordinates; offsets are zero outside the walk so the same
  // path serves the center cell.
  assign ox = (state_r == S_WALK) ? dx_r : '0;
  assign oy = (state_r == S_WALK) ? dy_r : '0;
  assign oz = (state_r == S_WALK) ? dz_r : '0;
  assign nx = CRD_W'(signed'({1'b0, x_r})) + CRD_W'(ox);
  assign ny = CRD_W'(signed'({1'b0, y_r})) + CRD_W'(oy);
  assign nz = CRD_W'(signed'({1'b0, z_r})) + CRD_W'(oz);
  assign coord_inside = (nx >= 0) && (nx < DIM_S) && (ny >= 0) && (ny < DIM_S) &&
                        (nz >= 0) && (nz < DIM_S);
  assign nbr_addr = {nx[GRID_DIM_BITS-1:0], ny[GRID_DIM_BITS-1:0], nz[GRID_DIM_BITS-1:0]};

  // Center value, its class and the clipped update sum.
  assign ctr_val = pend_in_r ? signed'(ram_rdata) : '0;
  assign ctr_cls = (ctr_val > 0) ? vomf_pkg::CLS_OCCUPIED :
                   (ctr_val < 0) ? vomf_pkg::CLS_EMPTY : vomf_pkg::CLS_UNOBSERVED;
  assign lo_mag  = (empty_limit_r > 8'd128) ? 8'd128 : empty_limit_r;
  assign sum     = 10'(ctr_val) + 10'(delta_r);
  assign lo      = -signed'({2'b00, lo_mag});
  assign hi      = signed'({3'b000, occ_limit_r});
  assign clipped = (sum > hi) ? hi : ((sum < lo) ? lo : sum);

  assign walk_last = (dx_r == OFS_HI) && (dy_r == OFS_HI) && (dz_r == OFS_HI);

  assign ram_we    = (state_r == S_CLEAR) ||
                     ((state_r == S_CTR_DATA) && (cmd_r == vomf_pkg::CMD_UPDATE) && pend_in_r);
  assign ram_addr  = (state_r == S_CLEAR) ? clr_cnt_r : nbr_addr;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : clipped[vomf_pkg::VAL_W-1:0];

  assign acc_ctl.clr     = (state_r == S_CTR_DATA);
  assign acc_ctl.vld     = pend_vld_r;
  assign acc_ctl.in_grid = pend_in_r;
  assign acc_ctl.finish  = (state_r == S_CMP);

  vomf_ram #(
    .WIDTH (vomf_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  vomf_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (acc_ctl),
    .rd_data   (signed'(ram_rdata)),
    .bounds    (bounds_r),
    .counts    (counts),
    .bounds_ok (bounds_ok)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cmd_nxt        = cmd_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    delta_nxt      = delta_r;
    mask_nxt       = mask_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    dz_nxt         = dz_r;
    value_nxt      = value_r;
    acc_nxt        = acc_r;
    out_tdata_nxt  = out_tdata_r;
    pend_vld_nxt   = (state_r == S_WALK);
    pend_in_nxt    = coord_inside;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          x_nxt     = in_tdata[4:0];
          y_nxt     = in_tdata[9:5];
          z_nxt     = in_tdata[14:10];
          delta_nxt = signed'(in_tdata[22:15]);
          mask_nxt  = in_tdata[25:23];
          state_nxt = S_CTR;
        end
      end
      S_CTR: begin
        state_nxt = S_CTR_DATA;
      end
      S_CTR_DATA: begin
        acc_nxt   = 1'b0;
        value_nxt = ctr_val;
        state_nxt = S_DONE;
        case (cmd_r)
          vomf_pkg::CMD_UPDATE: begin
            value_nxt = pend_in_r ? clipped[vomf_pkg::VAL_W-1:0] : '0;
          end
          vomf_pkg::CMD_TEST: begin
            acc_nxt   = |(ctr_cls & mask_r);
            dx_nxt    = OFS_LO;
            dy_nxt    = OFS_LO;
            dz_nxt    = OFS_LO;
            state_nxt = S_WALK;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        if (dz_r == OFS_HI) begin
          dz_nxt = OFS_LO;
          if (dy_r == OFS_HI) begin
            dy_nxt = OFS_LO;
            dx_nxt = dx_r + 1'b1;
          end else begin
            dy_nxt = dy_r + 1'b1;
          end
        end else begin
          dz_nxt = dz_r + 1'b1;
        end
        if (walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000, counts.occ, counts.empty, counts.unobs,
                            acc_r & bounds_ok, acc_r, value_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      pend_vld_r   <= 1'b0;
      pend_in_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      pend_vld_r   <= pend_vld_nxt;
      pend_in_r    <= pend_in_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cmd_r       <= cmd_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    delta_r     <= delta_nxt;
    mask_r      <= mask_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    dz_r        <= dz_nxt;
    value_r     <= value_nxt;
    acc_r       <= acc_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_limit_r        <= vomf_pkg::OCC_LIMIT_RST;
      empty_limit_r      <= vomf_pkg::EMPTY_LIMIT_RST;
      bounds_r.min_unobs <= vomf_pkg::MIN_BOUND_RST;
      bounds_r.max_unobs <= vomf_pkg::MAX_BOUND_RST;
      bounds_r.min_emp   <= vomf_pkg::MIN_BOUND_RST;
      bounds_r.max_emp   <= vomf_pkg::MAX_BOUND_RST;
      bounds_r.min_occ   <= vomf_pkg::MIN_BOUND_RST;
      bounds_r.max_occ   <= vomf_pkg::MAX_BOUND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        vomf_pkg::REG_OCC_LIMIT:   occ_limit_r        <= cfg_data[6:0];
        vomf_pkg::REG_EMPTY_LIMIT: empty_limit_r      <= cfg_data[7:0];
        vomf_pkg::REG_MIN_UNOBS:   bounds_r.min_unobs <= cfg_data;
        vomf_pkg::REG_MAX_UNOBS:   bounds_r.max_unobs <= cfg_data;
        vomf_pkg::REG_MIN_EMPTY:   bounds_r.min_emp   <= cfg_data;
        vomf_pkg::REG_MAX_EMPTY:   bounds_r.max_emp   <= cfg_data;
        vomf_pkg::REG_MIN_OCC:     bounds_r.min_occ   <= cfg_data;
        vomf_pkg::REG_MAX_OCC:     bounds_r.max_occ   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

`ifndef SYNTHESIS
  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat taken while an item is in progress");

  a_update_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (cmd_r == vomf_pkg::CMD_UPDATE) |->
      value_r <= signed'({1'b0, occ_limit_r}))
    else $error("stored update value above the occupancy limit");

  a_counts_cover_cube: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |->
      (11'(counts.unobs) + 11'(counts.empty) + 11'(counts.occ)) == 11'(NBR_CNT))
    else $error("neighbor counts do not add up to the cube size");

  a_pass_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[9] && !out_tdata_r[8]))
    else $error("pass reported for a rejected center class");
`endif

endmodule
`default_nettype wire
